### sv/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, widths and calendar helpers for the date-plus-days block.
// ----------------------------------------------------------------------------
package gda_pkg;

	localparam int MAX_ADD_DAYS_DEF = 65535;
	localparam int MAX_YEAR_DEF     = 9999;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int ADD_W   = 16;

	// year mod 400 is kept incrementally during the walk
	localparam int Y400_W         = 9;
	localparam int LEAP_CYCLE     = 400;
	localparam int MOD_STEPS      = 6;
	localparam int MOD_STEP_W     = 3;
	localparam int MOD_SUB_W      = 15;

	localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
	localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
	localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

	typedef struct packed {
		logic [YEAR_W-1:0]  start_year;
		logic [MONTH_W-1:0] start_month;
		logic [DAY_W-1:0]   start_day;
		logic [ADD_W-1:0]   days_to_add;
	} in_item_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  result_year;
		logic [MONTH_W-1:0] result_month;
		logic [DAY_W-1:0]   result_day;
		logic               year_overflow;
	} out_item_t;

	function automatic logic is_leap(input logic [Y400_W-1:0] y400);
		logic cent;
		cent = (y400 == Y400_W'(100)) || (y400 == Y400_W'(200)) || (y400 == Y400_W'(300));
		return (y400[1:0] == 2'b00) && !cent;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		case (m)
			MONTH_FEB:                         len = leap ? DAY_W'(29) : DAY_W'(28);
			MONTH_W'(4), MONTH_W'(6),
			MONTH_W'(9), MONTH_W'(11):         len = DAY_W'(30);
			default:                           len = DAY_W'(31);
		endcase
		return len;
	endfunction

endpackage

### sv/gda_stream_if.sv
// ----------------------------------------------------------------------------
// gda_stream_if
// Valid/ready channel carrying one item per accepted handshake.
// ----------------------------------------------------------------------------
interface gda_stream_if #(
	parameter type item_t = logic
);
	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

### sv/gda_walk.sv
// ----------------------------------------------------------------------------
// gda_walk
// Sequencer around one shared subtractor: reduces the start year mod 400,
// then walks one month per cycle until the day fits its month.
// ----------------------------------------------------------------------------
module gda_walk #(
	parameter int MAX_ADD_DAYS = gda_pkg::MAX_ADD_DAYS_DEF,
	parameter int MAX_YEAR     = gda_pkg::MAX_YEAR_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  gda_pkg::in_item_t  start_item,
	output logic               start_ready,
	output logic               res_valid,
	input  logic               res_ready,
	output gda_pkg::out_item_t res
);

	localparam int DSUM_W = $clog2(MAX_ADD_DAYS + 32);
	localparam int YR_W   = $clog2((1 << gda_pkg::YEAR_W) + MAX_ADD_DAYS / 365 + 4);
	localparam int SUB_W  = (DSUM_W > gda_pkg::MOD_SUB_W) ? DSUM_W : gda_pkg::MOD_SUB_W;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MOD  = 4'b0010,
		S_WALK = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t                             state_q;
	logic [gda_pkg::MOD_STEP_W-1:0]     step_q;
	logic [DSUM_W-1:0]                  day_q;
	logic [gda_pkg::MONTH_W-1:0]        month_q;
	logic [YR_W-1:0]                    year_q;
	logic [gda_pkg::YEAR_W-1:0]         rem_q;

	logic [gda_pkg::Y400_W-1:0]         y400;
	logic [gda_pkg::DAY_W-1:0]          cur_len;
	logic [SUB_W-1:0]                   op_a;
	logic [SUB_W-1:0]                   op_b;
	logic [SUB_W-1:0]                   diff;
	logic                               borrow;
	logic                               ovf;
	logic [DSUM_W-1:0]                  add_sat;
	logic [gda_pkg::YEAR_W-1:0]         year_in;
	logic [gda_pkg::MONTH_W-1:0]        month_in;
	logic [gda_pkg::DAY_W-1:0]          day_in;

	assign y400    = rem_q[gda_pkg::Y400_W-1:0];
	assign cur_len = gda_pkg::month_len(month_q, gda_pkg::is_leap(y400));

	// shared subtract/compare unit
	always_comb begin
		if (state_q == S_MOD) begin
			op_a = SUB_W'(rem_q);
			op_b = SUB_W'(gda_pkg::LEAP_CYCLE) << step_q;
		end else begin
			op_a = SUB_W'(day_q);
			op_b = SUB_W'(cur_len);
		end
		{borrow, diff} = {1'b0, op_a} - {1'b0, op_b};
	end

	// input normalization
	always_comb begin
		year_in  = (start_item.start_year == '0) ? gda_pkg::YEAR_W'(1) : start_item.start_year;
		month_in = start_item.start_month;
		if (start_item.start_month == '0) begin
			month_in = gda_pkg::MONTH_JAN;
		end else if (start_item.start_month > gda_pkg::MONTH_DEC) begin
			month_in = gda_pkg::MONTH_DEC;
		end
		day_in  = (start_item.start_day == '0) ? gda_pkg::DAY_W'(1) : start_item.start_day;
		add_sat = (32'(start_item.days_to_add) > 32'(MAX_ADD_DAYS)) ?
			DSUM_W'(MAX_ADD_DAYS) : DSUM_W'(start_item.days_to_add);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_MOD;
						step_q  <= gda_pkg::MOD_STEP_W'(gda_pkg::MOD_STEPS - 1);
					end
				end
				S_MOD: begin
					if (step_q == '0) begin
						state_q <= S_WALK;
					end else begin
						step_q <= step_q - gda_pkg::MOD_STEP_W'(1);
					end
				end
				S_WALK: begin
					if (borrow || diff == '0) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			year_q  <= YR_W'(year_in);
			rem_q   <= year_in;
			month_q <= month_in;
			day_q   <= DSUM_W'(day_in) + add_sat;
		end else if (state_q == S_MOD) begin
			if (!borrow) begin
				rem_q <= diff[gda_pkg::YEAR_W-1:0];
			end
		end else if (state_q == S_WALK) begin
			if (!borrow && diff != '0) begin
				day_q <= diff[DSUM_W-1:0];
				if (month_q == gda_pkg::MONTH_DEC) begin
					month_q <= gda_pkg::MONTH_JAN;
					year_q  <= year_q + YR_W'(1);
					rem_q   <= (rem_q == gda_pkg::YEAR_W'(gda_pkg::LEAP_CYCLE - 1)) ?
						'0 : rem_q + gda_pkg::YEAR_W'(1);
				end else begin
					month_q <= month_q + gda_pkg::MONTH_W'(1);
				end
			end
		end
	end

	assign ovf         = 32'(year_q) > 32'(MAX_YEAR);
	assign start_ready = (state_q == S_IDLE);
	assign res_valid   = (state_q == S_DONE);

	always_comb begin
		res.result_year   = ovf ? gda_pkg::YEAR_W'(MAX_YEAR) : year_q[gda_pkg::YEAR_W-1:0];
		res.result_month  = month_q;
		res.result_day    = day_q[gda_pkg::DAY_W-1:0];
		res.year_overflow = ovf;
	end

	a_start_to_mod: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == S_IDLE) |=> (state_q == S_MOD))
		else $error("walk did not enter year reduction");

	a_month_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK || state_q == S_DONE) |->
			(month_q >= gda_pkg::MONTH_JAN && month_q <= gda_pkg::MONTH_DEC))
		else $error("month out of range during walk");

	a_rem_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (rem_q < gda_pkg::YEAR_W'(gda_pkg::LEAP_CYCLE)))
		else $error("year mod 400 not reduced");

	a_day_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) |-> (day_q != '0 && day_q <= DSUM_W'(cur_len)))
		else $error("result day does not fit its month");

endmodule

### sv/gregorian_date_add_days.sv
// sequence: after accept, the start year is reduced mod 400 on the shared subtractor, then
// the walk crosses month boundaries one by one (at default limits at most about 2155 per item)
// flow: one item at a time; the next item is accepted once the previous result is in the
// output register, so a stalled output register also holds back the next accept
// reset: arst_n clears the sequencer and the output valid; no item is held after reset
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a day count to a Gregorian date, with year saturation on overflow.
// ----------------------------------------------------------------------------
module gregorian_date_add_days #(
	parameter int MAX_ADD_DAYS = gda_pkg::MAX_ADD_DAYS_DEF,
	parameter int MAX_YEAR     = gda_pkg::MAX_YEAR_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	gda_stream_if.sink   in_ch,
	gda_stream_if.source out_ch
);

	logic               walk_ready;
	logic               walk_valid;
	logic               walk_take;
	gda_pkg::out_item_t walk_res;
	logic               out_valid_q;
	gda_pkg::out_item_t out_item_q;

	gda_walk #(
		.MAX_ADD_DAYS (MAX_ADD_DAYS),
		.MAX_YEAR     (MAX_YEAR)
	) u_walk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_ch.valid),
		.start_item  (in_ch.payload),
		.start_ready (walk_ready),
		.res_valid   (walk_valid),
		.res_ready   (walk_take),
		.res         (walk_res)
	);

	assign in_ch.ready = walk_ready;
	assign walk_take   = !out_valid_q || out_ch.ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (walk_take) begin
			out_valid_q <= walk_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (walk_take && walk_valid) begin
			out_item_q <= walk_res;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.payload = out_item_q;

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stream-level check of the date-plus-days block. Directed calendar corners
// (leap rules, year wrap, clamped fields, year saturation) are followed by
// random dates, mostly well formed with some raw noise. Every accepted date
// is predicted in the bench and compared field by field in arrival order.
// Both channels stall in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module tb_top;
	import gda_pkg::*;

	localparam int RAND_ITEMS  = 250;
	localparam int CALM_TAIL   = 30;
	localparam int STALL_LIMIT = 12000;
	localparam int DRAIN_WAIT  = 20;

	class date_scoreboard;
		out_item_t due_q[$];
		int n_in;
		int n_out;
		int n_ovf;
		int n_err;

		function bit leap_year(int unsigned yr);
			return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
		endfunction

		function int unsigned month_days(int unsigned yr, int unsigned mo);
			int unsigned len;
			case (mo)
				2:             len = leap_year(yr) ? 29 : 28;
				4, 6, 9, 11:   len = 30;
				default:       len = 31;
			endcase
			return len;
		endfunction

		function out_item_t add_days(in_item_t it);
			int unsigned yr;
			int unsigned mo;
			int unsigned dy;
			int unsigned span;
			out_item_t   r;
			yr   = it.start_year;
			mo   = it.start_month;
			dy   = it.start_day;
			span = it.days_to_add;
			if (yr == 0) yr = 1;
			if (mo == 0) mo = 1;
			if (mo > 12) mo = 12;
			if (dy == 0) dy = 1;
			if (span > MAX_ADD_DAYS_DEF) span = MAX_ADD_DAYS_DEF;
			dy += span;
			while (dy > month_days(yr, mo)) begin
				dy -= month_days(yr, mo);
				mo++;
				if (mo == 13) begin
					mo = 1;
					yr++;
				end
			end
			r.year_overflow = 1'b0;
			if (yr > MAX_YEAR_DEF) begin
				yr = MAX_YEAR_DEF;
				r.year_overflow = 1'b1;
			end
			r.result_year  = YEAR_W'(yr);
			r.result_month = MONTH_W'(mo);
			r.result_day   = DAY_W'(dy);
			return r;
		endfunction

		function void note_date(in_item_t it);
			due_q.push_back(add_days(it));
			n_in++;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		task report_miss(string what, int got, int want);
			n_err++;
			if (n_err <= 40)
				$display("mismatch %0d at %0t: %s got %0d want %0d", n_err, $realtime, what,
					got, want);
		endtask

		task check_date(out_item_t got);
			out_item_t want;
			if (due_q.size() == 0) begin
				report_miss("result with nothing pending, year", got.result_year, 0);
				return;
			end
			want = due_q.pop_front();
			n_out++;
			if (want.year_overflow) n_ovf++;
			if (got.result_year !== want.result_year)
				report_miss("result_year", got.result_year, want.result_year);
			if (got.result_month !== want.result_month)
				report_miss("result_month", got.result_month, want.result_month);
			if (got.result_day !== want.result_day)
				report_miss("result_day", got.result_day, want.result_day);
			if (got.year_overflow !== want.year_overflow)
				report_miss("year_overflow", got.year_overflow, want.year_overflow);
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   idle_on = 1'b1;
	int   stall_cycles = 0;

	gda_stream_if #(.item_t(in_item_t))  in_ch ();
	gda_stream_if #(.item_t(out_item_t)) out_ch ();

	date_scoreboard sb = new;

	gregorian_date_add_days dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n         = 1'b0;
		in_ch.valid    = 1'b0;
		in_ch.payload  = '0;
		out_ch.ready   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// result side back-pressure
	initial begin
		@(posedge clk iff arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 2) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_date(in_ch.payload);
			if (out_ch.valid && out_ch.ready)
				sb.check_date(out_ch.payload);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	initial begin
		@(posedge clk iff arst_n);
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic in_item_t mk_date(int yr, int mo, int dy, int span);
		in_item_t it;
		it.start_year  = YEAR_W'(yr);
		it.start_month = MONTH_W'(mo);
		it.start_day   = DAY_W'(dy);
		it.days_to_add = ADD_W'(span);
		return it;
	endfunction

	function automatic int rand_span();
		int span;
		case ($urandom_range(0, 3))
			0:       span = $urandom_range(0, 40);
			1:       span = $urandom_range(0, 1500);
			2:       span = $urandom_range(0, 65535);
			default: span = $urandom_range(0, 400);
		endcase
		return span;
	endfunction

	function automatic in_item_t rand_date();
		int yr;
		int mo;
		int kind;
		in_item_t it;
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			yr = $urandom_range(1, 9999);
			mo = $urandom_range(1, 12);
			it = mk_date(yr, mo, $urandom_range(1, sb.month_days(yr, mo)), rand_span());
		end else if (kind == 6) begin
			yr = $urandom_range(9800, 9999);
			mo = $urandom_range(1, 12);
			it = mk_date(yr, mo, $urandom_range(1, sb.month_days(yr, mo)),
				$urandom_range(0, 65535));
		end else if (kind == 7) begin
			it = in_item_t'($urandom);
			it.start_year = YEAR_W'($urandom);
		end else if (kind == 8) begin
			case ($urandom_range(0, 2))
				0:       yr = 400 * $urandom_range(1, 24);
				1:       yr = 100 * $urandom_range(1, 99);
				default: yr = 4 * $urandom_range(1, 2499);
			endcase
			it = mk_date(yr, 2, $urandom_range(27, 29), $urandom_range(0, 3));
		end else begin
			it = mk_date($urandom_range(0, 16383), $urandom_range(0, 15),
				$urandom_range(0, 31), $urandom_range(0, 100));
		end
		return it;
	endfunction

	task automatic push_date(in_item_t it);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= it;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	initial begin
		in_item_t dir_q[$];
		int total;
		int sent;
		@(posedge clk iff arst_n);

		dir_q.push_back(mk_date(2024, 2, 28, 1));
		dir_q.push_back(mk_date(2023, 2, 28, 1));
		dir_q.push_back(mk_date(1900, 2, 28, 1));
		dir_q.push_back(mk_date(2000, 2, 28, 1));
		dir_q.push_back(mk_date(2023, 12, 31, 1));
		dir_q.push_back(mk_date(1, 1, 1, 0));
		dir_q.push_back(mk_date(1, 1, 1, 65535));
		dir_q.push_back(mk_date(9999, 12, 31, 0));
		dir_q.push_back(mk_date(9999, 12, 31, 1));
		dir_q.push_back(mk_date(9999, 12, 31, 65535));
		dir_q.push_back(mk_date(0, 5, 10, 3));
		dir_q.push_back(mk_date(2021, 0, 15, 20));
		dir_q.push_back(mk_date(2021, 13, 5, 30));
		dir_q.push_back(mk_date(2021, 15, 1, 0));
		dir_q.push_back(mk_date(2021, 6, 0, 0));
		dir_q.push_back(mk_date(2023, 2, 31, 0));
		dir_q.push_back(mk_date(2024, 2, 31, 0));
		dir_q.push_back(mk_date(2019, 4, 31, 0));
		dir_q.push_back(mk_date(10000, 1, 1, 0));
		dir_q.push_back(mk_date(16383, 15, 31, 65535));
		dir_q.push_back(mk_date(1999, 1, 1, 36524));
		dir_q.push_back(mk_date(0, 0, 0, 0));

		total = dir_q.size() + RAND_ITEMS;
		sent  = 0;
		foreach (dir_q[i]) begin
			push_date(dir_q[i]);
			sent++;
		end
		repeat (RAND_ITEMS) begin
			if (total - sent <= CALM_TAIL) idle_on = 1'b0;
			push_date(rand_date());
			sent++;
		end
		in_ch.valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("dates in: %0d, results checked: %0d, year saturations: %0d",
			sb.n_in, sb.n_out, sb.n_ovf);
		$display("leap rules, year wrap, clamped fields and random spans up to 65535 days");
		if (sb.n_err == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

### filelist.f
sv/gda_pkg.sv
sv/gda_stream_if.sv
sv/gda_walk.sv
sv/gregorian_date_add_days.sv
bench/tb_top.sv
